// File: rtl/m3i_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_pkg: shared types and constants of the 3x3 matrix inverse
// Element, cofactor and determinant widths and the word passed from the
// cofactor/determinant front end to the divider lanes.
// ---------------------------------------------------------------------------
package m3i_pkg;

  localparam int ELEMS        = 9;
  localparam int ELEM_W       = 32;
  localparam int COF_W        = 64;
  localparam int DET_W        = 97;
  localparam int REM_W        = 129;
  localparam int Q_BITS       = 32;
  localparam int FRONT_STAGES = 6;
  localparam int LANE_STAGES  = Q_BITS + 1;

  localparam logic [Q_BITS-1:0] Q_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_BITS-1:0] Q_NEG_MIN = 32'h8000_0000;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;

  // Determinant summary shared by all nine lanes.
  typedef struct packed {
    logic             sing;
    logic             dneg;
    logic [DET_W-1:0] dmag;
  } front_t;

endpackage

// File: rtl/m3i_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_in_if / m3i_out_if: valid/ready channels of the matrix inverse
// One word is one matrix on the input side and one inverse on the output.
// ---------------------------------------------------------------------------
interface m3i_in_if;
  logic          valid;
  logic          ready;
  m3i_pkg::elem_t in_0, in_1, in_2, in_3, in_4, in_5, in_6, in_7, in_8;

  modport source(output valid, in_0, in_1, in_2, in_3, in_4, in_5, in_6, in_7, in_8,
                 input ready);
  modport sink(input valid, in_0, in_1, in_2, in_3, in_4, in_5, in_6, in_7, in_8,
               output ready);
endinterface

interface m3i_out_if;
  logic          valid;
  logic          ready;
  m3i_pkg::elem_t out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7, out_8;
  logic          singular;

  modport source(output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
                 out_8, singular, input ready);
  modport sink(input valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
               out_8, singular, output ready);
endinterface

// File: rtl/m3i_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_front: cofactors and determinant
// Six register stages: products, cofactors, split 32x64 partial products,
// full products, determinant sum, and magnitudes/signs for the dividers.
// ---------------------------------------------------------------------------
module m3i_front (
  input  logic                          clk,
  input  logic                          en,
  input  m3i_pkg::elem_t                m     [m3i_pkg::ELEMS],
  output logic [m3i_pkg::COF_W-1:0]     cm_o  [m3i_pkg::ELEMS],
  output logic                          cneg_o[m3i_pkg::ELEMS],
  output m3i_pkg::front_t               fr_o
);

  localparam int N = m3i_pkg::ELEMS;

  // Operand pairs of the cofactor products: cf[i] = m[PA]*m[PB] - m[PC]*m[PD].
  localparam int PA [N] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int PB [N] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int PC [N] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int PD [N] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  m3i_pkg::cof_t  pa_r [N];
  m3i_pkg::cof_t  pb_r [N];
  m3i_pkg::elem_t col1_r [3];
  m3i_pkg::elem_t col2_r [3];
  m3i_pkg::cof_t  cf2_r [N];
  m3i_pkg::cof_t  cf3_r [N];
  m3i_pkg::cof_t  cf4_r [N];
  m3i_pkg::cof_t  cf5_r [N];
  logic signed [64:0] lo_r [3];
  m3i_pkg::cof_t  hi_r [3];
  m3i_pkg::det_t  prod_r [3];
  m3i_pkg::det_t  det_r;
  m3i_pkg::det_t  prod_nxt [3];

  // Stage 1: eighteen 32x32 products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        pa_r[i] <= m3i_pkg::cof_t'(m[PA[i]]) * m3i_pkg::cof_t'(m[PB[i]]);
        pb_r[i] <= m3i_pkg::cof_t'(m[PC[i]]) * m3i_pkg::cof_t'(m[PD[i]]);
      end
      col1_r[0] <= m[0];
      col1_r[1] <= m[3];
      col1_r[2] <= m[6];
    end
  end

  // Stage 2: cofactors as differences of two products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        cf2_r[i] <= pa_r[i] - pb_r[i];
      end
      col2_r <= col1_r;
    end
  end

  // Stage 3: first column times its cofactors, split at bit 32.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        lo_r[j] <= 65'(col2_r[j]) * $signed({33'd0, cf2_r[j][31:0]});
        hi_r[j] <= m3i_pkg::cof_t'(col2_r[j]) * m3i_pkg::cof_t'($signed(cf2_r[j][63:32]));
      end
      cf3_r <= cf2_r;
    end
  end

  // Stage 4: reassemble the 96-bit products.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod_nxt[j] = (m3i_pkg::det_t'(hi_r[j]) <<< 32) + m3i_pkg::det_t'(lo_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      cf4_r  <= cf3_r;
    end
  end

  // Stage 5: determinant.
  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= prod_r[0] + prod_r[1] + prod_r[2];
      cf5_r <= cf4_r;
    end
  end

  // Stage 6: magnitudes and signs for the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      fr_o.sing <= (det_r == '0);
      fr_o.dneg <= det_r[m3i_pkg::DET_W-1];
      fr_o.dmag <= det_r[m3i_pkg::DET_W-1] ? m3i_pkg::DET_W'(-det_r)
                                          : m3i_pkg::DET_W'(det_r);
      for (int i = 0; i < N; i++) begin
        cneg_o[i] <= cf5_r[i][m3i_pkg::COF_W-1];
        cm_o[i]   <= cf5_r[i][m3i_pkg::COF_W-1] ? m3i_pkg::COF_W'(-cf5_r[i])
                                               : m3i_pkg::COF_W'(cf5_r[i]);
      end
    end
  end

endmodule

// File: rtl/m3i_div_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_div_lane: pipelined restoring divider for one inverse element
// One quotient bit per stage (32 stages), then rounding and saturation.
// ---------------------------------------------------------------------------
module m3i_div_lane (
  input  logic                         clk,
  input  logic                         en,
  input  logic [m3i_pkg::COF_W-1:0]    cm,
  input  logic                         cneg,
  input  m3i_pkg::front_t              fr,
  output logic [m3i_pkg::Q_BITS-1:0]   q_o
);

  localparam int STEPS = m3i_pkg::Q_BITS;
  localparam int RW    = m3i_pkg::REM_W;
  localparam int DW    = m3i_pkg::DET_W;
  localparam int QW    = m3i_pkg::Q_BITS;

  logic [RW-1:0] rem_in [STEPS];
  logic [QW-1:0] quo_in [STEPS];
  logic [DW-1:0] dmag_in[STEPS];
  logic          neg_in [STEPS];
  logic          sat_in [STEPS];
  logic          zero_in[STEPS];

  logic [RW-1:0] rem_r  [STEPS];
  logic [QW-1:0] quo_r  [STEPS];
  logic [DW-1:0] dmag_r [STEPS];
  logic          neg_r  [STEPS];
  logic          sat_r  [STEPS];
  logic          zero_r [STEPS];

  logic          rnd;
  logic [QW:0]   qf;
  logic [QW-1:0] res_nxt;

  // Entry: numerator is |cofactor| * 2^32; saturate when it reaches |det| * 2^32.
  assign rem_in[0]  = RW'({cm, {QW{1'b0}}});
  assign quo_in[0]  = '0;
  assign dmag_in[0] = fr.dmag;
  assign neg_in[0]  = cneg ^ fr.dneg;
  assign sat_in[0]  = (DW'(cm) >= fr.dmag);
  assign zero_in[0] = (cm == '0) | fr.sing;

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int B = STEPS - 1 - s;
    logic [RW-1:0] sub;
    logic          ge;

    if (s > 0) begin : g_link
      assign rem_in[s]  = rem_r[s-1];
      assign quo_in[s]  = quo_r[s-1];
      assign dmag_in[s] = dmag_r[s-1];
      assign neg_in[s]  = neg_r[s-1];
      assign sat_in[s]  = sat_r[s-1];
      assign zero_in[s] = zero_r[s-1];
    end

    // Trial subtraction of the divisor aligned to this quotient bit.
    assign sub = RW'(dmag_in[s]) << B;
    assign ge  = (rem_in[s] >= sub);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? rem_in[s] - sub : rem_in[s];
        quo_r[s]  <= quo_in[s] | (ge ? (QW'(1) << B) : '0);
        dmag_r[s] <= dmag_in[s];
        neg_r[s]  <= neg_in[s];
        sat_r[s]  <= sat_in[s];
        zero_r[s] <= zero_in[s];
      end
    end
  end

  // Round half away from zero on the magnitude, then apply sign and saturate.
  always_comb begin
    rnd = ({rem_r[STEPS-1][DW-1:0], 1'b0} >= {1'b0, dmag_r[STEPS-1]});
    qf  = sat_r[STEPS-1] ? {1'b1, {QW{1'b0}}}
                         : {1'b0, quo_r[STEPS-1]} + (QW+1)'(rnd);
    if (zero_r[STEPS-1]) begin
      res_nxt = '0;
    end else if (neg_r[STEPS-1]) begin
      res_nxt = (qf >= (QW+1)'(m3i_pkg::Q_NEG_MIN)) ? m3i_pkg::Q_NEG_MIN
                                                  : QW'(-qf);
    end else begin
      res_nxt = (qf >= (QW+1)'(m3i_pkg::Q_NEG_MIN)) ? m3i_pkg::Q_POS_MAX
                                                  : qf[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_o <= res_nxt;
    end
  end

endmodule

// File: rtl/matrix3_inverse_core.sv
`timescale 1ns / 1ps
// An accepted word passes 6 front-end stages for cofactors and determinant, 32
// divider stages and one rounding/output stage on its way to its result.
// Throughput: one matrix per cycle unless held; bit-per-stage lanes set depth.
// The whole pipeline holds when the output register is full and not taken.
// Reset clears the valid bits only; datapath registers are not reset.
// ---------------------------------------------------------------------------
// matrix3_inverse_core: 3x3 Q16.16 matrix inverse, adjugate over determinant
// Nine cofactors and the determinant feed nine pipelined dividers whose
// quotients are rounded to nearest and saturated; zero determinant flags.
// ---------------------------------------------------------------------------
module matrix3_inverse_core (
  input  logic       clk,
  input  logic       rst_n,
  m3i_in_if.sink     in_ch,
  m3i_out_if.source  out_ch
);

  localparam int N   = m3i_pkg::ELEMS;
  localparam int LAT = m3i_pkg::FRONT_STAGES + m3i_pkg::LANE_STAGES;
  localparam int LS  = m3i_pkg::LANE_STAGES;

  logic                          en;
  m3i_pkg::elem_t                m    [N];
  logic [m3i_pkg::COF_W-1:0]     cm   [N];
  logic                          cneg [N];
  logic [m3i_pkg::Q_BITS-1:0]    q    [N];
  m3i_pkg::front_t               fr;
  logic                          vld_r [LAT];
  logic                          sing_r[LS];

  // The pipeline advances unless a finished word sits unclaimed at the output.
  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  assign m[0] = in_ch.in_0;
  assign m[1] = in_ch.in_1;
  assign m[2] = in_ch.in_2;
  assign m[3] = in_ch.in_3;
  assign m[4] = in_ch.in_4;
  assign m[5] = in_ch.in_5;
  assign m[6] = in_ch.in_6;
  assign m[7] = in_ch.in_7;
  assign m[8] = in_ch.in_8;

  m3i_front u_front (
    .clk    (clk),
    .en     (en),
    .m      (m),
    .cm_o   (cm),
    .cneg_o (cneg),
    .fr_o   (fr)
  );

  for (genvar i = 0; i < N; i++) begin : g_lane
    m3i_div_lane u_lane (
      .clk  (clk),
      .en   (en),
      .cm   (cm[i]),
      .cneg (cneg[i]),
      .fr   (fr),
      .q_o  (q[i])
    );
  end

  // Valid bits travel alongside the datapath stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Singular flag follows the divider lanes.
  always_ff @(posedge clk) begin
    if (en) begin
      sing_r[0] <= fr.sing;
      for (int i = 1; i < LS; i++) begin
        sing_r[i] <= sing_r[i-1];
      end
    end
  end

  assign out_ch.valid    = vld_r[LAT-1];
  assign out_ch.singular = sing_r[LS-1];
  assign out_ch.out_0    = $signed(q[0]);
  assign out_ch.out_1    = $signed(q[1]);
  assign out_ch.out_2    = $signed(q[2]);
  assign out_ch.out_3    = $signed(q[3]);
  assign out_ch.out_4    = $signed(q[4]);
  assign out_ch.out_5    = $signed(q[5]);
  assign out_ch.out_6    = $signed(q[6]);
  assign out_ch.out_7    = $signed(q[7]);
  assign out_ch.out_8    = $signed(q[8]);

endmodule
